@@ hw/rtl/pop3_response_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// pop3 response deframer assertion macros
// shared check helpers for the deframer rtl
// ----------------------------------------------------------------------------
`ifndef POP3_RESPONSE_DEFRAMER_DEFINES_SVH
`define POP3_RESPONSE_DEFRAMER_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define P3D_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define P3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pop3_df_pkg.sv @@
// ----------------------------------------------------------------------------
// pop3 deframer package
// character codes, terminator tables, result item type and status decode
// ----------------------------------------------------------------------------
`default_nettype none

package pop3_df_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_READY = 2'd1,
    STATUS_ERR   = 2'd2
  } status_e;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_UC_O  = 8'h4F;
  localparam logic [7:0] CHR_LC_O  = 8'h6F;
  localparam logic [7:0] CHR_UC_K  = 8'h4B;
  localparam logic [7:0] CHR_LC_K  = 8'h6B;

  localparam int NUM_TERMS = 4;
  localparam int MAX_ITEMS = 5;
  localparam int HOLD_DEPTH = 4;

  // 0,1 multi-line terminators; 2,3 single-line terminators
  localparam logic [2:0] TERM_LEN [NUM_TERMS] = '{3'd5, 3'd3, 3'd2, 3'd1};
  localparam logic [7:0] TERM_BYTE [NUM_TERMS][MAX_ITEMS] = '{
    '{CHR_CR, CHR_LF, CHR_DOT, CHR_CR, CHR_LF},
    '{CHR_LF, CHR_DOT, CHR_LF, 8'h00, 8'h00},
    '{CHR_CR, CHR_LF, 8'h00, 8'h00, 8'h00},
    '{CHR_LF, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [7:0] data;
    logic       status_line;
    logic       done;
    logic [1:0] status;
  } item_t;

  function automatic status_e status_code(input logic [7:0] s0, input logic [7:0] s1,
                                          input logic [7:0] s2, input logic [2:0] cnt);
    status_e res;
    res = STATUS_ERR;
    if (cnt >= 3'd2 && s0 == CHR_PLUS && (s1 == CHR_SPACE || s1 == CHR_TAB)) begin
      res = STATUS_READY;
    end else if (cnt >= 3'd3 && s0 == CHR_PLUS && (s1 == CHR_UC_O || s1 == CHR_LC_O) &&
                 (s2 == CHR_UC_K || s2 == CHR_LC_K)) begin
      res = STATUS_OK;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pop3_response_deframer.sv @@
// a beat taken into the input register passes its first result through the pending buffer to the output register
// throughput: one input beat per cycle while each beat releases at most one result and the output is not stalled
// a beat releasing m results (up to five) holds them in the pending buffer, input stalls until the last one pops
// held-back beats and beats after done give no result
// reset: asynchronous active low, clears all framing state as for a new single-line response
// ----------------------------------------------------------------------------
// pop3 response deframer
// status classification, dot unstuffing and terminator removal, one byte a beat
// ----------------------------------------------------------------------------
`default_nettype none
`include "pop3_response_deframer_defines.svh"

module pop3_response_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       start_of_response_i,
  input  wire logic       multi_line_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            in_status_line_o,
  output logic            done_res_o,
  output logic [1:0]      status_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_sor_q;
  logic       in_ml_q;

  // framing state
  logic [7:0] hold_q [4];
  logic [7:0] hold_d [4];
  logic [2:0] hold_cnt_q, hold_cnt_d;
  logic [1:0] line_pos_q, line_pos_d;
  logic       dot_dropped_q, dot_dropped_d;
  logic [7:0] stat_q [3];
  logic [7:0] stat_d [3];
  logic [2:0] byte_cnt_q, byte_cnt_d;
  logic       mode_multi_q, mode_multi_d;
  logic       first_line_q, first_line_d;
  logic       finished_q, finished_d;

  // pending results and output register
  pop3_df_pkg::item_t pend_q [5];
  pop3_df_pkg::item_t step_items [5];
  logic [2:0]         pend_cnt_q;
  logic [2:0]         step_cnt;
  logic               step_hit;
  logic               live;
  logic               proc;
  logic               pend_pop;
  logic               out_free;
  logic               in_accept;
  logic               out_vld_q;
  pop3_df_pkg::item_t out_q;

  assign live      = in_sor_q || !finished_q;
  assign out_free  = !out_vld_q || !out_stall_i;
  assign pend_pop  = (pend_cnt_q != 3'd0) && out_free;
  assign proc      = in_vld_q && ((pend_cnt_q == 3'd0) || ((pend_cnt_q == 3'd1) && pend_pop));
  assign in_stall_o = in_vld_q && !proc;
  assign in_accept = in_valid_i && !in_stall_o;

  // one step of the framer on the registered beat
  always_comb begin
    logic [2:0] hc;
    logic [1:0] lp;
    logic       dd;
    logic       fl;
    logic       mm;
    logic [2:0] bc;
    logic [7:0] tail [5];
    logic [7:0] seq [5];
    logic [2:0] idx;
    logic [2:0] n;
    logic [3:0] en;
    logic       ok;
    logic       any;
    logic [2:0] hit_len;
    logic [2:0] keep;
    logic [2:0] rel;
    logic [2:0] cnt;
    logic [7:0] rb;
    pop3_df_pkg::item_t it;

    rb = 8'h00;
    it = '0;

    if (in_sor_q) begin
      hc = 3'd0;
      lp = 2'd0;
      dd = 1'b0;
      fl = 1'b1;
      mm = in_ml_q;
      bc = 3'd0;
      for (int i = 0; i < 3; i++) stat_d[i] = 8'h00;
    end else begin
      hc = hold_cnt_q;
      lp = line_pos_q;
      dd = dot_dropped_q;
      fl = first_line_q;
      mm = mode_multi_q;
      bc = byte_cnt_q;
      for (int i = 0; i < 3; i++) stat_d[i] = stat_q[i];
    end

    if (bc < 3'd3) stat_d[bc[1:0]] = in_byte_q;
    byte_cnt_d = (bc < 3'd4) ? bc + 3'd1 : bc;

    // tail[k] is the k-th byte back from the newest one
    tail[0] = in_byte_q;
    for (int k = 1; k < 5; k++) begin
      idx = hc - 3'(k);
      tail[k] = (3'(k) <= hc) ? hold_q[idx[1:0]] : 8'h00;
    end
    for (int i = 0; i < 4; i++) seq[i] = (3'(i) < hc) ? hold_q[i] : in_byte_q;
    seq[4] = in_byte_q;
    n = hc + 3'd1;

    if (mm) begin
      en[0] = 1'b1;
      en[1] = 1'b1;
      en[2] = (stat_d[0] == pop3_df_pkg::CHR_MINUS) && (byte_cnt_d >= 3'd4);
      en[3] = en[2];
    end else begin
      en = 4'b1100;
    end

    // earliest table entry wins
    step_hit = 1'b0;
    hit_len  = 3'd0;
    for (int t = pop3_df_pkg::NUM_TERMS - 1; t >= 0; t--) begin
      ok = en[t] && (n >= pop3_df_pkg::TERM_LEN[t]);
      for (int j = 0; j < 5; j++) begin
        if (j < int'(pop3_df_pkg::TERM_LEN[t])) begin
          if (tail[int'(pop3_df_pkg::TERM_LEN[t]) - 1 - j] != pop3_df_pkg::TERM_BYTE[t][j]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        step_hit = 1'b1;
        hit_len  = pop3_df_pkg::TERM_LEN[t];
      end
    end

    // longest tail that could still grow into a terminator
    keep = 3'd0;
    for (int k = 1; k <= pop3_df_pkg::HOLD_DEPTH; k++) begin
      any = 1'b0;
      for (int t = 0; t < pop3_df_pkg::NUM_TERMS; t++) begin
        ok = en[t] && (pop3_df_pkg::TERM_LEN[t] > 3'(k)) && (3'(k) <= n);
        for (int j = 0; j < k; j++) begin
          if (tail[k - 1 - j] != pop3_df_pkg::TERM_BYTE[t][j]) ok = 1'b0;
        end
        if (ok) any = 1'b1;
      end
      if (any) keep = 3'(k);
    end

    rel = step_hit ? n - hit_len : n - keep;

    for (int i = 0; i < 5; i++) step_items[i] = '0;
    cnt = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < rel) begin
        rb = seq[i];
        if (!fl && lp == 2'd1 && rb == pop3_df_pkg::CHR_DOT && !dd) begin
          // stuffed dot dropped, at most once per line
          dd = 1'b1;
          lp = 2'd2;
        end else begin
          it             = '0;
          it.data        = rb;
          it.status_line = fl;
          step_items[cnt] = it;
          cnt = cnt + 3'd1;
          if (rb == pop3_df_pkg::CHR_LF) begin
            lp = 2'd0;
            dd = 1'b0;
            fl = 1'b0;
          end else if (lp == 2'd0 && rb == pop3_df_pkg::CHR_DOT) begin
            lp = 2'd1;
          end else begin
            lp = 2'd2;
          end
        end
      end
    end
    if (step_hit) begin
      it        = '0;
      it.done   = 1'b1;
      it.status = pop3_df_pkg::status_code(stat_d[0], stat_d[1], stat_d[2], byte_cnt_d);
      step_items[cnt] = it;
      cnt = cnt + 3'd1;
    end
    step_cnt = live ? cnt : 3'd0;

    line_pos_d    = lp;
    dot_dropped_d = dd;
    first_line_d  = fl;
    mode_multi_d  = mm;
    finished_d    = step_hit;
    hold_cnt_d    = step_hit ? 3'd0 : keep;
    for (int i = 0; i < 4; i++) begin
      idx = keep - 3'd1 - 3'(i);
      hold_d[i] = (3'(i) < keep) ? tail[idx] : hold_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
      in_sor_q  <= start_of_response_i;
      in_ml_q   <= multi_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) hold_q[i] <= 8'h00;
      for (int i = 0; i < 3; i++) stat_q[i] <= 8'h00;
      hold_cnt_q    <= 3'd0;
      line_pos_q    <= 2'd0;
      dot_dropped_q <= 1'b0;
      byte_cnt_q    <= 3'd0;
      mode_multi_q  <= 1'b0;
      first_line_q  <= 1'b1;
      finished_q    <= 1'b0;
    end else if (proc && live) begin
      for (int i = 0; i < 4; i++) hold_q[i] <= hold_d[i];
      for (int i = 0; i < 3; i++) stat_q[i] <= stat_d[i];
      hold_cnt_q    <= hold_cnt_d;
      line_pos_q    <= line_pos_d;
      dot_dropped_q <= dot_dropped_d;
      byte_cnt_q    <= byte_cnt_d;
      mode_multi_q  <= mode_multi_d;
      first_line_q  <= first_line_d;
      finished_q    <= finished_d;
    end
  end

  // pending results, shifted down one per beat out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 3'd0;
    end else if (proc) begin
      pend_cnt_q <= step_cnt;
    end else if (pend_pop) begin
      pend_cnt_q <= pend_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int i = 0; i < 5; i++) pend_q[i] <= step_items[i];
    end else if (pend_pop) begin
      for (int i = 0; i < 4; i++) pend_q[i] <= pend_q[i + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= (pend_cnt_q != 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_pop) begin
      out_q <= pend_q[0];
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_byte_o       = out_q.data;
  assign byte_valid_o     = !out_q.done;
  assign in_status_line_o = out_q.status_line;
  assign done_res_o       = out_q.done;
  assign status_o         = out_q.status;

  `P3D_ASSERT_ALWAYS(a_pend_bound, clk_i, rst_ni, pend_cnt_q <= 3'd5, "pending count overflow")
  `P3D_ASSERT_ALWAYS(a_hold_bound, clk_i, rst_ni, hold_cnt_q <= 3'd4, "hold count overflow")
  `P3D_ASSERT_ALWAYS(a_done_empty, clk_i, rst_ni, !finished_q || hold_cnt_q == 3'd0,
                     "bytes held after done")
  `P3D_ASSERT_NEXT(a_hit_finish, clk_i, rst_ni, proc && live && step_hit, finished_q,
                   "terminator did not finish response")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pop3 response deframer testbench
// drives single-line, multi-line and malformed responses a byte a beat with
// random gaps and stalls, predicts status, unstuffing and terminator removal
// in a scoreboard and checks every result beat field by field
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PERCENT   = 32;
  localparam int TARGET_BEATS   = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  // terminator table indexes: multi-line pair first, single-line pair last
  localparam int MULTI_TERM_FIRST  = 0;
  localparam int MULTI_TERM_LAST   = 1;
  localparam int SINGLE_TERM_FIRST = 2;
  localparam int SINGLE_TERM_LAST  = 3;
  localparam int DASH_TERM_LAST    = 3;

  typedef enum logic [1:0] {
    LINE_START,
    LINE_AFTER_DOT,
    LINE_BODY
  } line_phase_e;

  typedef struct {
    logic [7:0]           data;
    logic                 byte_valid;
    logic                 status_line;
    logic                 done;
    pop3_df_pkg::status_e status;
  } deframe_item_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       multi;
  } rx_beat_t;

  class deframe_scoreboard;
    deframe_item_t expected_q[$];
    int            errors;
    logic [7:0]    term_seq[4][5];
    int            term_n[4];
    logic [7:0]    held[4];
    int            held_cnt;
    line_phase_e   phase;
    bit            dot_gone;
    logic [7:0]    head[3];
    int            head_cnt;
    bit            multi_mode;
    bit            on_first_line;
    bit            resp_done;
    logic [7:0]    win[5];

    function new();
      term_seq[0] = '{pop3_df_pkg::CHR_CR, pop3_df_pkg::CHR_LF, pop3_df_pkg::CHR_DOT,
                      pop3_df_pkg::CHR_CR, pop3_df_pkg::CHR_LF};
      term_seq[1] = '{pop3_df_pkg::CHR_LF, pop3_df_pkg::CHR_DOT, pop3_df_pkg::CHR_LF,
                      8'h00, 8'h00};
      term_seq[2] = '{pop3_df_pkg::CHR_CR, pop3_df_pkg::CHR_LF, 8'h00, 8'h00, 8'h00};
      term_seq[3] = '{pop3_df_pkg::CHR_LF, 8'h00, 8'h00, 8'h00, 8'h00};
      term_n = '{5, 3, 2, 1};
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (held[i]) held[i] = 8'h00;
      foreach (head[i]) head[i] = 8'h00;
      held_cnt      = 0;
      phase         = LINE_START;
      dot_gone      = 1'b0;
      head_cnt      = 0;
      multi_mode    = 1'b0;
      on_first_line = 1'b1;
      resp_done     = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // released byte: drop one stuffed dot per line, outside the status line
    function void emit(logic [7:0] b);
      deframe_item_t it;
      if (!on_first_line && phase == LINE_AFTER_DOT && b == pop3_df_pkg::CHR_DOT &&
          !dot_gone) begin
        dot_gone = 1'b1;
        phase    = LINE_BODY;
        return;
      end
      it.data        = b;
      it.byte_valid  = 1'b1;
      it.status_line = on_first_line;
      it.done        = 1'b0;
      it.status      = pop3_df_pkg::STATUS_OK;
      expected_q = {expected_q, it};
      if (b == pop3_df_pkg::CHR_LF) begin
        phase         = LINE_START;
        dot_gone      = 1'b0;
        on_first_line = 1'b0;
      end else if (phase == LINE_START && b == pop3_df_pkg::CHR_DOT) begin
        phase = LINE_AFTER_DOT;
      end else begin
        phase = LINE_BODY;
      end
    endfunction

    function pop3_df_pkg::status_e classify();
      if (head_cnt >= 2 && head[0] == pop3_df_pkg::CHR_PLUS &&
          (head[1] == pop3_df_pkg::CHR_SPACE || head[1] == pop3_df_pkg::CHR_TAB))
        return pop3_df_pkg::STATUS_READY;
      if (head_cnt >= 3 && head[0] == pop3_df_pkg::CHR_PLUS &&
          (head[1] == pop3_df_pkg::CHR_UC_O || head[1] == pop3_df_pkg::CHR_LC_O) &&
          (head[2] == pop3_df_pkg::CHR_UC_K || head[2] == pop3_df_pkg::CHR_LC_K))
        return pop3_df_pkg::STATUS_OK;
      return pop3_df_pkg::STATUS_ERR;
    endfunction

    function bit tail_matches(int from, int t, int k);
      for (int i = 0; i < k; i++) begin
        if (win[from + i] != term_seq[t][i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // returns 0 when the beat is ignored after done
    function bit note_byte(logic [7:0] b, logic st, logic ml);
      int            n;
      int            lo;
      int            hi;
      int            keep;
      deframe_item_t fin;
      if (st) begin
        restart();
        multi_mode = ml;
      end else if (resp_done) begin
        return 1'b0;
      end
      if (head_cnt < 3) head[head_cnt] = b;
      if (head_cnt < 4) head_cnt++;
      for (int i = 0; i < held_cnt; i++) win[i] = held[i];
      win[held_cnt] = b;
      n = held_cnt + 1;
      if (multi_mode) begin
        lo = MULTI_TERM_FIRST;
        hi = (head[0] == pop3_df_pkg::CHR_MINUS && head_cnt >= 4) ? DASH_TERM_LAST :
             MULTI_TERM_LAST;
      end else begin
        lo = SINGLE_TERM_FIRST;
        hi = SINGLE_TERM_LAST;
      end
      for (int t = lo; t <= hi; t++) begin
        if (n >= term_n[t] && tail_matches(n - term_n[t], t, term_n[t])) begin
          for (int i = 0; i < n - term_n[t]; i++) emit(win[i]);
          fin.data        = 8'h00;
          fin.byte_valid  = 1'b0;
          fin.status_line = 1'b0;
          fin.done        = 1'b1;
          fin.status      = classify();
          expected_q = {expected_q, fin};
          resp_done = 1'b1;
          held_cnt  = 0;
          return 1'b1;
        end
      end
      // longest tail that could still grow into a terminator stays held
      keep = 0;
      for (int k = (n > 4 ? 4 : n); k >= 1 && keep == 0; k--) begin
        for (int t = lo; t <= hi; t++) begin
          if (keep == 0 && term_n[t] > k && tail_matches(n - k, t, k)) keep = k;
        end
      end
      for (int i = 0; i < n - keep; i++) emit(win[i]);
      for (int i = 0; i < keep; i++) held[i] = win[n - keep + i];
      held_cnt = keep;
      return 1'b1;
    endfunction

    function void check_result(logic [7:0] data, logic bv, logic sl, logic dn, logic [1:0] st);
      deframe_item_t exp_it;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: out_byte=%02h done_res=%0b", data, dn);
        errors++;
        return;
      end
      exp_it = expected_q.pop_front();
      if (data !== exp_it.data) begin
        $error("out_byte: expected %02h, got %02h", exp_it.data, data);
        errors++;
      end
      if (bv !== exp_it.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", exp_it.byte_valid, bv);
        errors++;
      end
      if (sl !== exp_it.status_line) begin
        $error("in_status_line: expected %0b, got %0b", exp_it.status_line, sl);
        errors++;
      end
      if (dn !== exp_it.done) begin
        $error("done_res: expected %0b, got %0b", exp_it.done, dn);
        errors++;
      end
      if (st !== exp_it.status) begin
        $error("status: expected %0d, got %0d", exp_it.status, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       start_of_response_i = 1'b0;
  logic       multi_line_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       in_status_line_o;
  logic       done_res_o;
  logic [1:0] status_o;

  deframe_scoreboard sb;
  rx_beat_t          beat_q[$];
  int                beats_taken = 0;
  int                quiet = 0;
  bit                steady = 1'b0;

  pop3_response_deframer uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte_i),
    .start_of_response_i (start_of_response_i),
    .multi_line_i        (multi_line_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_byte_o          (out_byte_o),
    .byte_valid_o        (byte_valid_o),
    .in_status_line_o    (in_status_line_o),
    .done_res_o          (done_res_o),
    .status_o            (status_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_result(out_byte_o, byte_valid_o, in_status_line_o, done_res_o, status_o);
    end
  end

  // counts cycles in which neither side moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_beat(logic [7:0] b, logic st, logic ml);
    rx_beat_t bt;
    bt.data  = b;
    bt.start = st;
    bt.multi = ml;
    beat_q = {beat_q, bt};
  endtask

  // continuation beat, multi bit is don't-care away from a start
  task automatic put(logic [7:0] b);
    push_beat(b, 1'b0, 1'($urandom_range(1, 0)));
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(9))
      6: c = pop3_df_pkg::CHR_DOT;
      7: c = pop3_df_pkg::CHR_CR;
      8: c = 8'($urandom_range(255));
      9: begin
        case ($urandom_range(5))
          0: c = pop3_df_pkg::CHR_PLUS;
          1: c = pop3_df_pkg::CHR_MINUS;
          2: c = pop3_df_pkg::CHR_UC_O;
          3: c = pop3_df_pkg::CHR_LC_K;
          4: c = pop3_df_pkg::CHR_SPACE;
          default: c = pop3_df_pkg::CHR_TAB;
        endcase
      end
      default: c = 8'($urandom_range(126, 32));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = pop3_df_pkg::CHR_CR;
      1: c = pop3_df_pkg::CHR_LF;
      2: c = pop3_df_pkg::CHR_DOT;
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  task automatic add_text(int len);
    repeat (len) put(text_char());
  endtask

  task automatic add_eol();
    if ($urandom_range(1, 0)) put(pop3_df_pkg::CHR_CR);
    put(pop3_df_pkg::CHR_LF);
  endtask

  task automatic gen_response();
    bit ml;
    int nl;
    ml = 1'($urandom_range(1, 0));
    if ($urandom_range(99) < 78) begin
      case ($urandom_range(5))
        0: begin
          push_beat(pop3_df_pkg::CHR_PLUS, 1'b1, ml);
          put($urandom_range(1, 0) ? pop3_df_pkg::CHR_UC_O : pop3_df_pkg::CHR_LC_O);
          put($urandom_range(1, 0) ? pop3_df_pkg::CHR_UC_K : pop3_df_pkg::CHR_LC_K);
        end
        1: begin
          push_beat(pop3_df_pkg::CHR_PLUS, 1'b1, ml);
          put($urandom_range(1, 0) ? pop3_df_pkg::CHR_SPACE : pop3_df_pkg::CHR_TAB);
        end
        2: begin
          push_beat(pop3_df_pkg::CHR_MINUS, 1'b1, ml);
          add_text($urandom_range(4));
        end
        3: begin
          push_beat(pop3_df_pkg::CHR_PLUS, 1'b1, ml);
          put($urandom_range(1, 0) ? pop3_df_pkg::CHR_UC_O : pop3_df_pkg::CHR_LC_O);
        end
        4: begin
          push_beat(pop3_df_pkg::CHR_PLUS, 1'b1, ml);
          put(8'($urandom_range(255)));
        end
        default: push_beat(text_char(), 1'b1, ml);
      endcase
      add_text($urandom_range(6));
      add_eol();
      if (ml) begin
        nl = $urandom_range(4);
        repeat (nl) begin
          repeat ($urandom_range(3)) put(pop3_df_pkg::CHR_DOT);
          add_text($urandom_range(5));
          add_eol();
        end
        put(pop3_df_pkg::CHR_DOT);
        add_eol();
      end
      // sometimes cut short so that the next start lands mid-response
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          if (beat_q.size() > 1) void'(beat_q.pop_back());
        end
      end
      if ($urandom_range(99) < 20) add_text($urandom_range(3, 1));
    end else begin
      push_beat(noise_char(), 1'b1, ml);
      repeat ($urandom_range(12, 1)) begin
        if ($urandom_range(99) < 8) push_beat(noise_char(), 1'b1, 1'($urandom_range(1, 0)));
        else put(noise_char());
      end
    end
  endtask

  task automatic drive_beats();
    rx_beat_t bt;
    while (beat_q.size() > 0) begin
      bt = beat_q.pop_front();
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i          <= 1'b1;
      rx_byte_i           <= bt.data;
      start_of_response_i <= bt.start;
      multi_line_i        <= bt.multi;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      if (sb.note_byte(bt.data, bt.start, bt.multi)) beats_taken++;
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no start yet: handled as a single-line response
    push_text("+oK\n");
    // ignored, the response is already done
    push_text("x");
    // ready status, stuffed dot on the second line, lf.lf terminator
    push_beat(pop3_df_pkg::CHR_PLUS, 1'b1, 1'b1);
    push_text(" \n..\n.\n");
    // abandoned by a new start, then a status line too short to classify
    push_beat(pop3_df_pkg::CHR_MINUS, 1'b1, 1'b0);
    push_text("E");
    push_beat(pop3_df_pkg::CHR_CR, 1'b1, 1'b0);
    push_beat(pop3_df_pkg::CHR_LF, 1'b0, 1'b0);
    // multi-line error ends on a plain lf once four bytes are in
    push_beat(pop3_df_pkg::CHR_MINUS, 1'b1, 1'b1);
    push_text("ERR\n");
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(pop3_df_pkg::CHR_LF, 1'b0, 1'b0);
    drive_beats();

    while (beats_taken < TARGET_BEATS) begin
      steady = (beats_taken >= 100 && beats_taken < 150);
      gen_response();
      drive_beats();
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
